// ----- sv/causal_delivery_vector_clock_defines.svh -----
// ----------------------------------------------------------------------------
// causal delivery assertion macros
// shared assertion forms for the causal delivery block
// ----------------------------------------------------------------------------
`ifndef CAUSAL_DELIVERY_VECTOR_CLOCK_DEFINES_SVH
`define CAUSAL_DELIVERY_VECTOR_CLOCK_DEFINES_SVH

// property checked outside reset
`define CDVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every edge, reset included
`define CDVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/cdvc_pkg.sv -----
// ----------------------------------------------------------------------------
// cdvc_pkg
// types, codes and field widths of the causal delivery block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdvc_pkg;

  // group size and field widths
  localparam int MEMBERS     = 3;
  localparam int STAMP_W     = 16;
  localparam int SENDER_W    = 2;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 72;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_RECV  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DELIVERED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_HELD      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_STAMPED   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_REFUSED   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_MEMBER   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ACTIVE = 2'd1;

  // hold-back queue cell operations
  typedef logic [1:0] qop_t;
  localparam qop_t Q_HOLD   = 2'd0;
  localparam qop_t Q_APPEND = 2'd1;
  localparam qop_t Q_DROP   = 2'd2;
  localparam qop_t Q_ROTATE = 2'd3;

  // one held message
  typedef struct packed {
    logic [SENDER_W-1:0]             sender;
    logic [MEMBERS-1:0][STAMP_W-1:0] stamp;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0]             status;
    logic [SENDER_W-1:0]             origin;
    logic [MEMBERS-1:0][STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0]              ack;
  } result_t;

endpackage

// ----- sv/causal_delivery_vector_clock.sv -----
// Sequence: an input transfer latches the item, the execute state fills the result slot
//   and the output register takes it when free; a queue check on a non-empty queue
//   scans it, the result set at the first deliverable head or after the last compare.
// Flow: input waits for idle and an empty result slot; a scan visits every held entry.
// Reset: synchronous, clears the vector clock, queue count, registers and
//   handshake state; queue contents are not cleared.
// ----------------------------------------------------------------------------
// causal_delivery_vector_clock
// vector clock with a hold-back queue for causal group multicast delivery
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "causal_delivery_vector_clock_defines.svh"

module causal_delivery_vector_clock import cdvc_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  parameter int CLOCK_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sender, stamp_a, stamp_b, stamp_c, zero pad
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // origin_member, out_a, out_b, out_c, ack_seq, zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]    m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = ((CLOCK_BITS > STAMP_W) ? CLOCK_BITS : STAMP_W) + 1;
  localparam logic [CMP_W-1:0] CLK_MASK = CMP_W'((64'd1 << CLOCK_BITS) - 64'd1);
  localparam logic [STAMP_W-1:0] STAMP_MASK = CLK_MASK[STAMP_W-1:0];

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                        state;
  logic [SENDER_W-1:0]               own_member;
  logic                              group_active;
  logic [MEMBERS-1:0][CLOCK_BITS-1:0] clock_vec;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  rem;
  logic                              found;
  logic [CMD_W-1:0]                  cmd;
  entry_t                            item;
  result_t                           res;
  logic                              res_pend;
  result_t                           out_res;
  logic                              out_valid;

  entry_t                            cells [QUEUE_DEPTH];
  entry_t                            chk_entry;
  logic                              chk_ok;
  logic [MEMBERS-1:0][CLOCK_BITS-1:0] merged;
  logic [MEMBERS-1:0][CLOCK_BITS-1:0] send_vec;
  logic [MEMBERS-1:0][STAMP_W-1:0]   send_stamp;
  logic [STAMP_W-1:0]                ack;
  logic                              send_ok;
  qop_t                              qop;
  logic                              in_xfer;
  logic                              out_load;
  result_t                           exec_res;
  result_t                           scan_res;

  // clock entry to result field width
  function automatic logic [STAMP_W-1:0] to_stamp(input logic [CLOCK_BITS-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return w[STAMP_W-1:0];
  endfunction

  assign s_axis_tready = (state == ST_IDLE) && !res_pend;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_load      = res_pend && (!out_valid || m_axis_tready);

  // causal check on the latched item, or on the queue head while scanning
  assign chk_entry = (state == ST_SCAN) ? cells[0] : item;

  cdvc_check #(
    .CLOCK_BITS (CLOCK_BITS)
  ) u_check (
    .clock_vec (clock_vec),
    .entry     (chk_entry),
    .ok        (chk_ok),
    .merged    (merged)
  );

  // saturating own-entry increment and ack selection
  always_comb begin
    send_ok = group_active && (own_member < SENDER_W'(MEMBERS));
    ack     = '0;
    for (int i = 0; i < MEMBERS; i++) begin
      if (own_member == SENDER_W'(i) && clock_vec[i] != '1) begin
        send_vec[i] = clock_vec[i] + CLOCK_BITS'(1);
      end else begin
        send_vec[i] = clock_vec[i];
      end
      send_stamp[i] = to_stamp(send_vec[i]);
      if (item.sender == SENDER_W'(i)) begin
        ack = item.stamp[i];
      end
    end
  end

  // result of the executed command and of the queue head compare
  always_comb begin
    exec_res = '0;
    case (cmd)
      CMD_RECV: begin
        exec_res.origin = item.sender;
        exec_res.stamp  = item.stamp;
        exec_res.ack    = ack;
        if (chk_ok) begin
          exec_res.status = STAT_DELIVERED;
        end else if (count < CNT_W'(QUEUE_DEPTH)) begin
          exec_res.status = STAT_HELD;
        end else begin
          exec_res.status = STAT_DROPPED;
        end
      end
      CMD_SEND: begin
        exec_res.origin = own_member;
        if (send_ok) begin
          exec_res.status = STAT_STAMPED;
          exec_res.stamp  = send_stamp;
        end else begin
          exec_res.status = STAT_REFUSED;
        end
      end
      default: begin
        exec_res.status = STAT_NONE;
      end
    endcase
    scan_res        = '0;
    scan_res.status = STAT_NONE;
    if (!found && chk_ok) begin
      scan_res.status = STAT_DELIVERED;
      scan_res.origin = cells[0].sender;
      scan_res.stamp  = cells[0].stamp;
    end
  end

  // queue operation for this cycle
  always_comb begin
    qop = Q_HOLD;
    if (state == ST_EXEC && cmd == CMD_RECV && !chk_ok &&
        count < CNT_W'(QUEUE_DEPTH)) begin
      qop = Q_APPEND;
    end else if (state == ST_SCAN) begin
      qop = (!found && chk_ok) ? Q_DROP : Q_ROTATE;
    end
  end

  // row of queue cells, each fed by its upper neighbor, the last by itself
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t nxt;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = cells[g];
    end else begin : g_mid
      assign nxt = cells[g + 1];
    end
    cdvc_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .op         (qop),
      .count      (count),
      .next_entry (nxt),
      .head_entry (cells[0]),
      .new_entry  (item),
      .entry      (cells[g])
    );
  end

  // configuration, sequencer, clock and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      own_member   <= '0;
      group_active <= 1'b0;
      clock_vec    <= '0;
      count        <= '0;
      rem          <= '0;
      found        <= 1'b0;
      res_pend     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // configuration write
      if (cfg_valid) begin
        case (cfg_index)
          REG_OWN_MEMBER:   own_member   <= cfg_data[SENDER_W-1:0];
          REG_GROUP_ACTIVE: group_active <= cfg_data[0];
          default: ;
        endcase
      end

      // output register
      if (out_load) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        res_pend <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            cmd           <= s_axis_tuser;
            item.sender   <= s_axis_tdata[1:0];
            item.stamp[0] <= s_axis_tdata[17:2] & STAMP_MASK;
            item.stamp[1] <= s_axis_tdata[33:18] & STAMP_MASK;
            item.stamp[2] <= s_axis_tdata[49:34] & STAMP_MASK;
            state         <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res <= exec_res;
          // a check on a non-empty queue goes on to scan it
          if (cmd == CMD_CHECK && count != '0) begin
            rem   <= count;
            found <= 1'b0;
            state <= ST_SCAN;
          end else begin
            res_pend <= 1'b1;
            state    <= ST_IDLE;
          end
          if (cmd == CMD_RECV) begin
            if (chk_ok) begin
              clock_vec <= merged;
            end else if (count < CNT_W'(QUEUE_DEPTH)) begin
              count <= count + CNT_W'(1);
            end
          end else if (cmd == CMD_SEND && send_ok) begin
            clock_vec <= send_vec;
          end
        end
        ST_SCAN: begin
          rem <= rem - CNT_W'(1);
          // first deliverable head, or none after the last compare
          if (!found && (chk_ok || rem == CNT_W'(1))) begin
            res      <= scan_res;
            res_pend <= 1'b1;
          end
          // first deliverable head leaves the queue
          if (!found && chk_ok) begin
            clock_vec <= merged;
            count     <= count - CNT_W'(1);
            found     <= 1'b1;
          end
          if (rem == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // master side
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {6'd0, out_res.ack, out_res.stamp[2], out_res.stamp[1],
                          out_res.stamp[0], out_res.origin};

  // assertions
  `CDVC_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "held count above queue depth")
  `CDVC_ASSERT(a_accept_free, s_axis_tready |-> !res_pend, "input taken with result slot busy")
  `CDVC_ASSERT(a_scan_range, (state == ST_SCAN) |-> rem != '0 && rem <= count, "bad scan range")
  `CDVC_ASSERT_ALWAYS(a_reset_clear, rst |=> (!m_axis_tvalid && count == '0), "reset left state")

endmodule

// ----- sv/cdvc_check.sv -----
// ----------------------------------------------------------------------------
// cdvc_check
// causal condition of one message against the local clock, and merged clock
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdvc_check import cdvc_pkg::*; #(
  parameter int CLOCK_BITS = 16
) (
  input  logic [MEMBERS-1:0][CLOCK_BITS-1:0] clock_vec,
  input  entry_t                             entry,
  output logic                               ok,
  output logic [MEMBERS-1:0][CLOCK_BITS-1:0] merged
);

  localparam int CMP_W = ((CLOCK_BITS > STAMP_W) ? CLOCK_BITS : STAMP_W) + 1;

  logic [MEMBERS-1:0][CMP_W-1:0] lim;
  logic [MEMBERS-1:0][CMP_W-1:0] st;
  logic [MEMBERS-1:0][CMP_W-1:0] loc;
  logic [MEMBERS-1:0]            pass;

  // per-entry limit compare and elementwise maximum, no wrap
  always_comb begin
    for (int i = 0; i < MEMBERS; i++) begin
      loc[i]    = CMP_W'(clock_vec[i]);
      st[i]     = CMP_W'(entry.stamp[i]);
      lim[i]    = loc[i] + CMP_W'(entry.sender == SENDER_W'(i));
      pass[i]   = (st[i] <= lim[i]);
      merged[i] = (st[i] > loc[i]) ? CLOCK_BITS'(st[i]) : clock_vec[i];
    end
    ok = &pass;
  end

endmodule

// ----- sv/cdvc_cell.sv -----
// ----------------------------------------------------------------------------
// cdvc_cell
// one slot of the hold-back queue, shifting to its lower neighbor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdvc_cell import cdvc_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  qop_t             op,
  input  logic [CNT_W-1:0] count,
  input  entry_t           next_entry,
  input  entry_t           head_entry,
  input  entry_t           new_entry,
  output entry_t           entry
);

  // slot update: append at the tail, shift down, or rotate head to the tail
  always_ff @(posedge clk) begin
    case (op)
      Q_APPEND: begin
        if (CNT_W'(IDX) == count) begin
          entry <= new_entry;
        end
      end
      Q_DROP: begin
        entry <= next_entry;
      end
      Q_ROTATE: begin
        if (CNT_W'(IDX + 1) == count) begin
          entry <= head_entry;
        end else begin
          entry <= next_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule
